// ===== rtl/srdd_pkg.sv =====
// Shared types and constants for the sorted ID delta run decoder.
// No dependencies; used by every module in rtl/.
package srdd_pkg;

    localparam int OUT_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int RUN_W       = 6;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    // Top two bits of a run byte
    localparam logic [1:0] RUN_TAG = 2'b01;

    typedef enum logic [1:0] {
        CMD_DELTA,
        CMD_RUN,
        CMD_ERROR,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [RUN_W-1:0]   count;
        logic               clear;
    } cmd_ctrl_t;

endpackage

// ===== rtl/srdd_front.sv =====
// Front end: accepts code bytes, assembles varint deltas, queues commands.
// Depends on srdd_pkg.
module srdd_front #(
    parameter int ID_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [srdd_pkg::BYTE_W-1:0]    s_code_byte,
    input  logic                           s_chunk_end,
    input  logic                           q_full,
    output logic                           q_push,
    output srdd_pkg::cmd_ctrl_t            q_ctrl,
    output logic [ID_WIDTH-1:0]            q_value
);

    logic [ID_WIDTH-1:0] accum_reg, accum_next;
    logic                in_varint_reg, in_varint_next;
    logic                accept;
    logic                need_push;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && need_push;

    always_comb begin
        accum_next     = accum_reg;
        in_varint_next = in_varint_reg;
        need_push      = 1'b0;
        q_ctrl.kind    = srdd_pkg::CMD_DELTA;
        q_ctrl.count   = s_code_byte[srdd_pkg::RUN_W-1:0];
        q_ctrl.clear   = s_chunk_end;
        q_value        = {accum_reg[ID_WIDTH-7:0], s_code_byte[5:0]};
        if (s_code_byte[7]) begin
            // continuation: 7 more bits into the accumulator
            accum_next     = {accum_reg[ID_WIDTH-8:0], s_code_byte[6:0]};
            in_varint_next = 1'b1;
            need_push      = s_chunk_end;
            q_ctrl.kind    = srdd_pkg::CMD_ERROR;
            q_ctrl.clear   = 1'b1;
        end else if (!in_varint_reg && s_code_byte[7:6] == srdd_pkg::RUN_TAG) begin
            if (s_code_byte[srdd_pkg::RUN_W-1:0] != '0) begin
                q_ctrl.kind = srdd_pkg::CMD_RUN;
                need_push   = 1'b1;
            end else begin
                q_ctrl.kind = srdd_pkg::CMD_CLEAR;
                need_push   = s_chunk_end;
            end
        end else begin
            accum_next     = '0;
            in_varint_next = 1'b0;
            need_push      = 1'b1;
        end
        if (s_chunk_end) begin
            accum_next     = '0;
            in_varint_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg     <= '0;
            in_varint_reg <= 1'b0;
        end else if (accept) begin
            accum_reg     <= accum_next;
            in_varint_reg <= in_varint_next;
        end
    end

endmodule

// ===== rtl/srdd_fifo.sv =====
// Short command queue between front and back end.
// Depends on srdd_pkg.
module srdd_fifo #(
    parameter int ID_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  srdd_pkg::cmd_ctrl_t     push_ctrl,
    input  logic [ID_WIDTH-1:0]     push_value,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output srdd_pkg::cmd_ctrl_t     head_ctrl,
    output logic [ID_WIDTH-1:0]     head_value
);

    srdd_pkg::cmd_ctrl_t           ctrl_mem [srdd_pkg::Q_DEPTH];
    logic [ID_WIDTH-1:0]           value_mem [srdd_pkg::Q_DEPTH];
    logic [srdd_pkg::Q_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [srdd_pkg::Q_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                          do_push, do_pop;

    assign full       = (cnt_reg == srdd_pkg::Q_CNT_W'(srdd_pkg::Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;
    assign head_ctrl  = ctrl_mem[rd_ptr_reg];
    assign head_value = value_mem[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ctrl_mem[wr_ptr_reg]  <= push_ctrl;
            value_mem[wr_ptr_reg] <= push_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/srdd_back.sv =====
// Back end: executes queued commands, keeps the running ID and repeat delta,
// drives the result output register. Depends on srdd_pkg.
module srdd_back #(
    parameter int ID_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  srdd_pkg::cmd_ctrl_t         q_ctrl,
    input  logic [ID_WIDTH-1:0]         q_value,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [srdd_pkg::OUT_W-1:0]  m_id_value,
    output logic                        m_run_last,
    output logic                        m_malformed
);

    logic [ID_WIDTH-1:0]          running_reg, running_next;
    logic [ID_WIDTH-1:0]          repeat_reg, repeat_next;
    logic [srdd_pkg::RUN_W-1:0]   run_cnt_reg, run_cnt_next;
    logic                         m_valid_reg;
    logic [srdd_pkg::OUT_W-1:0]   m_id_reg;
    logic                         m_last_reg, m_bad_reg;
    logic                         out_free, fire, emit;
    logic [ID_WIDTH-1:0]          sum_id, res_id;
    logic                         res_last, res_bad;
    logic [srdd_pkg::OUT_W-1:0]   res_id_out;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = q_valid && (q_ctrl.kind == srdd_pkg::CMD_CLEAR || out_free);

    always_comb begin
        running_next = running_reg;
        repeat_next  = repeat_reg;
        run_cnt_next = run_cnt_reg;
        emit         = 1'b0;
        q_pop        = 1'b0;
        sum_id       = running_reg + repeat_reg;
        res_id       = sum_id;
        res_last     = 1'b1;
        res_bad      = 1'b0;
        if (fire) begin
            case (q_ctrl.kind)
                srdd_pkg::CMD_DELTA: begin
                    sum_id       = running_reg + q_value;
                    res_id       = sum_id;
                    running_next = sum_id;
                    repeat_next  = q_value;
                    emit         = 1'b1;
                    q_pop        = 1'b1;
                end
                srdd_pkg::CMD_RUN: begin
                    running_next = sum_id;
                    emit         = 1'b1;
                    res_last     = (run_cnt_reg == q_ctrl.count - 1'b1);
                    if (res_last) begin
                        run_cnt_next = '0;
                        q_pop        = 1'b1;
                    end else begin
                        run_cnt_next = run_cnt_reg + 1'b1;
                    end
                end
                srdd_pkg::CMD_ERROR: begin
                    res_id  = '0;
                    res_bad = 1'b1;
                    emit    = 1'b1;
                    q_pop   = 1'b1;
                end
                default: begin
                    q_pop = 1'b1;
                end
            endcase
            if (q_pop && q_ctrl.clear) begin
                running_next = '0;
                repeat_next  = '0;
            end
        end
    end

    generate
        if (ID_WIDTH >= srdd_pkg::OUT_W) begin : g_trunc
            assign res_id_out = res_id[srdd_pkg::OUT_W-1:0];
        end else begin : g_ext
            assign res_id_out = {{(srdd_pkg::OUT_W-ID_WIDTH){1'b0}}, res_id};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_id_reg   <= res_id_out;
            m_last_reg <= res_last;
            m_bad_reg  <= res_bad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= '0;
            repeat_reg  <= '0;
            run_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            running_reg <= running_next;
            repeat_reg  <= repeat_next;
            run_cnt_reg <= run_cnt_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_id_value  = m_id_reg;
    assign m_run_last  = m_last_reg;
    assign m_malformed = m_bad_reg;

    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_bad_reg |-> m_last_reg && m_id_reg == '0)
        else $error("error item with nonzero id or without last");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ctrl.kind == srdd_pkg::CMD_RUN |-> run_cnt_reg < q_ctrl.count)
        else $error("run counter past run length");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid_reg)
        else $error("emitted item not presented");

    a_idle_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> run_cnt_reg == '0)
        else $error("run counter busy with empty queue");

endmodule

// ===== rtl/sorted_id_delta_run_decoder.sv =====
// Sorted ID delta run decoder, top level. Bytes pass the command queue and output
// register. The back end gives one result per cycle unless the output stalls; a
// run byte with count N gives N results, a varint continuation byte none unless
// it ends a chunk. Input takes one byte per cycle while the 4-entry command queue
// has room. Synchronous active-low reset clears control state; no clearing pass.
module sorted_id_delta_run_decoder #(
    parameter int ID_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [srdd_pkg::BYTE_W-1:0] s_code_byte,
    input  logic                        s_chunk_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [srdd_pkg::OUT_W-1:0]  m_id_value,
    output logic                        m_run_last,
    output logic                        m_malformed
);

    srdd_pkg::cmd_ctrl_t    push_ctrl, head_ctrl;
    logic [ID_WIDTH-1:0]    push_value, head_value;
    logic                   push, full, pop, head_valid;

    srdd_front #(.ID_WIDTH(ID_WIDTH)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_byte (s_code_byte),
        .s_chunk_end (s_chunk_end),
        .q_full      (full),
        .q_push      (push),
        .q_ctrl      (push_ctrl),
        .q_value     (push_value)
    );

    srdd_fifo #(.ID_WIDTH(ID_WIDTH)) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ctrl  (push_ctrl),
        .push_value (push_value),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_ctrl  (head_ctrl),
        .head_value (head_value)
    );

    srdd_back #(.ID_WIDTH(ID_WIDTH)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (head_valid),
        .q_ctrl      (head_ctrl),
        .q_value     (head_value),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_id_value  (m_id_value),
        .m_run_last  (m_run_last),
        .m_malformed (m_malformed)
    );

endmodule

// ===== bench/sorted_id_delta_run_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sorted_id_delta_run_decoder: directed and random byte streams,
// with a scoreboard class that decodes each accepted byte and checks every result item.
// Depends on rtl/srdd_pkg.sv and rtl/sorted_id_delta_run_decoder.sv.

typedef struct {
    logic [srdd_pkg::OUT_W-1:0] id_value;
    logic                       run_last;
    logic                       malformed;
} decoded_id_t;

class decoded_id_board;
    localparam int ID_W = 32;

    logic [ID_W-1:0] run_id;
    logic [ID_W-1:0] rep_delta;
    logic [ID_W-1:0] accum;
    bit              in_vint;
    int              errors;
    decoded_id_t     expected_ids[$];

    function new();
        run_id    = '0;
        rep_delta = '0;
        accum     = '0;
        in_vint   = 1'b0;
        errors    = 0;
    endfunction

    function void push_id(logic [ID_W-1:0] id, logic last, logic bad);
        decoded_id_t r;
        r.id_value  = id[srdd_pkg::OUT_W-1:0];
        r.run_last  = last;
        r.malformed = bad;
        expected_ids.insert(expected_ids.size(), r);
    endfunction

    function void predict_ids(logic [srdd_pkg::BYTE_W-1:0] b, logic chunk_end);
        logic [ID_W-1:0] d;
        int              n;
        if (b[7]) begin
            accum   = (accum << 7) | ID_W'(b[6:0]);
            in_vint = 1'b1;
        end else if (!in_vint && b[7:6] == srdd_pkg::RUN_TAG) begin
            n = int'(b[srdd_pkg::RUN_W-1:0]);
            for (int i = 0; i < n; i++) begin
                run_id = run_id + rep_delta;
                push_id(run_id, i == n - 1, 1'b0);
            end
        end else begin
            d         = (accum << 6) | ID_W'(b[srdd_pkg::RUN_W-1:0]);
            run_id    = run_id + d;
            rep_delta = d;
            accum     = '0;
            in_vint   = 1'b0;
            push_id(run_id, 1'b1, 1'b0);
        end
        if (chunk_end) begin
            if (in_vint)
                push_id('0, 1'b1, 1'b1);
            run_id    = '0;
            rep_delta = '0;
            accum     = '0;
            in_vint   = 1'b0;
        end
    endfunction

    function void check_result(logic [srdd_pkg::OUT_W-1:0] id, logic last, logic bad);
        decoded_id_t r;
        if (expected_ids.size() == 0) begin
            errors++;
            $display("%0t: unexpected item id=%h last=%b malformed=%b", $time, id, last, bad);
            return;
        end
        r = expected_ids.pop_front();
        if (id !== r.id_value) begin
            errors++;
            $display("%0t: id_value expected %h got %h", $time, r.id_value, id);
        end
        if (last !== r.run_last) begin
            errors++;
            $display("%0t: run_last expected %b got %b", $time, r.run_last, last);
        end
        if (bad !== r.malformed) begin
            errors++;
            $display("%0t: malformed expected %b got %b", $time, r.malformed, bad);
        end
    endfunction

    function int pending();
        return expected_ids.size();
    endfunction
endclass

module sorted_id_delta_run_decoder_tb;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [srdd_pkg::BYTE_W-1:0]    s_code_byte;
    logic                           s_chunk_end;
    logic                           m_valid;
    logic                           m_ready;
    logic [srdd_pkg::OUT_W-1:0]     m_id_value;
    logic                           m_run_last;
    logic                           m_malformed;

    decoded_id_board sb;
    bit              hold_req;
    int              rx_mode;
    int              burst_left;
    int              bytes_sent;

    sorted_id_delta_run_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_byte (s_code_byte),
        .s_chunk_end (s_chunk_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_id_value  (m_id_value),
        .m_run_last  (m_run_last),
        .m_malformed (m_malformed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_id_value, m_run_last, m_malformed);
            if (s_valid && s_ready)
                sb.predict_ids(s_code_byte, s_chunk_end);
        end
    end

    // receiver: always ready, or ready/stall stretches of random length, or held off on hold_req
    initial begin
        int  stretch_left;
        bit  level;
        stretch_left = 0;
        level        = 1'b1;
        m_ready      = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (rx_mode == 0) begin
                m_ready = 1'b1;
            end else begin
                if (stretch_left == 0) begin
                    level        = $urandom_range(0, 9) < 7;
                    stretch_left = $urandom_range(1, 8);
                end
                m_ready = level;
                stretch_left--;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic put_byte(input logic [srdd_pkg::BYTE_W-1:0] b, input logic chunk_end);
        @(negedge aclk);
        s_valid     = 1'b1;
        s_code_byte = b;
        s_chunk_end = chunk_end;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid     = 1'b0;
            s_code_byte = srdd_pkg::BYTE_W'($urandom_range(0, 255));
            s_chunk_end = 1'($urandom_range(0, 1));
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic send_item(input logic [srdd_pkg::BYTE_W-1:0] b, input logic chunk_end);
        put_byte(b, chunk_end);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    task automatic random_sequence();
        int                         pick;
        int                         k;
        logic                       end_bit;
        logic [srdd_pkg::RUN_W-1:0] n;
        pick    = $urandom_range(0, 99);
        end_bit = ($urandom_range(0, 14) == 0);
        if (pick < 40) begin
            send_item({2'b00, 6'($urandom_range(0, 63))}, end_bit);
        end else if (pick < 65) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            for (int i = 0; i < k; i++) begin
                if (i == k - 1 && $urandom_range(0, 11) == 0) begin
                    // chunk ends mid-varint
                    send_item({1'b1, 7'($urandom_range(0, 127))}, 1'b1);
                    return;
                end
                send_item({1'b1, 7'($urandom_range(0, 127))}, 1'b0);
            end
            if ($urandom_range(0, 4) == 0)
                send_item({srdd_pkg::RUN_TAG, 6'($urandom_range(0, 63))}, end_bit);
            else
                send_item({2'b00, 6'($urandom_range(0, 63))}, end_bit);
        end else if (pick < 85) begin
            n = srdd_pkg::RUN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(7, 63)
                                                            : $urandom_range(0, 6));
            send_item({srdd_pkg::RUN_TAG, n}, end_bit);
        end else begin
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        sb          = new();
        hold_req    = 1'b0;
        rx_mode     = 1;
        burst_left  = $urandom_range(1, 16);
        bytes_sent  = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_code_byte = '0;
        s_chunk_end = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed
        send_item({srdd_pkg::RUN_TAG, 6'd5}, 1'b0);     // run before any delta
        send_item({srdd_pkg::RUN_TAG, 6'd0}, 1'b0);     // empty run
        send_item(8'h00, 1'b0);
        send_item(8'h3f, 1'b0);
        send_item(8'h7f, 1'b0);                 // longest run
        send_item(8'h81, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h40, 1'b0);                 // run-tagged byte terminates varint
        for (int i = 0; i < 6; i++)
            send_item(8'hff, 1'b0);             // overlong varint
        send_item(8'h3f, 1'b0);
        send_item(8'hc5, 1'b1);                 // chunk ends inside varint
        send_item(8'h10, 1'b1);
        send_item(8'h41, 1'b0);                 // run after chunk clear
        send_item(8'h8f, 1'b0);
        for (int i = 0; i < 4; i++)
            send_item(8'hff, 1'b0);
        send_item(8'h3f, 1'b0);                 // huge delta, id wraps
        send_item(8'h42, 1'b1);                 // run with chunk end

        idle_sender(1);
        wait_drained();

        // receiver holds off while the sender keeps offering items
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item((i % 2) ? {srdd_pkg::RUN_TAG, 6'd3} : 8'(i + 1), 1'b0);

        bytes_sent = 0;
        while (bytes_sent < 100)
            random_sequence();
        rx_mode = 0;
        while (bytes_sent < 160)
            random_sequence();
        idle_sender(1);
        wait_drained();
        rx_mode = 1;
        while (bytes_sent < 215)
            random_sequence();

        idle_sender(1);
        wait_drained();
        repeat (20) @(negedge aclk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
